@@ sv/bitmap_slot_allocator_core_assert.svh @@
// Assertion macros shared by the slot allocator RTL.
`ifndef BITMAP_SLOT_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_SLOT_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define BSA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define BSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define BSA_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define BSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ sv/bsa_pkg.sv @@
// Types and constants of the bitmap slot allocator.
package bsa_pkg;

   localparam int ADDR_W         = 32;
   localparam int STATUS_W       = 3;
   localparam int COUNT_REG_W    = 11;
   localparam int SIZE_W         = 16;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 32;
   localparam int DIV_DIVIDEND_W = 32;
   localparam int DIV_DIVISOR_W  = 16;
   localparam int DIV_CNT_W      = 5;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic [COUNT_REG_W-1:0] SLOT_COUNT_RESET  = 11'd1024;
   localparam logic [SIZE_W-1:0]      SLOT_SIZE_RESET   = 16'd64;
   localparam logic [ADDR_W-1:0]      OBJECT_BASE_RESET = 32'd0;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK            = 3'd0,
      STATUS_FULL          = 3'd1,
      STATUS_MISALIGNED    = 3'd2,
      STATUS_RANGE         = 3'd3,
      STATUS_NOT_ALLOCATED = 3'd4
   } bsa_status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SLOT_COUNT  = 2'd0,
      CSR_SLOT_SIZE   = 2'd1,
      CSR_OBJECT_BASE = 2'd2
   } bsa_csr_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_ALLOC_MUL,
      S_ALLOC_ADD,
      S_DIVIDE,
      S_FREE_MUL,
      S_FREE_FIX,
      S_FREE_CHECK,
      S_RESP
   } bsa_state_type;

   typedef struct packed {
      logic                      done;
      logic [DIV_DIVIDEND_W-1:0] quotient;
      logic [DIV_DIVISOR_W-1:0]  remainder;
   } bsa_div_result_type;

endpackage

@@ sv/bsa_map_ram.sv @@
// Synchronous used-slot bitmap memory with one write and one registered read port.
module bsa_map_ram #(
   parameter int WORDS = 32,
   parameter int WIDTH = 32,
   parameter int AW    = 5
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data
);

   logic [WIDTH-1:0] mem [WORDS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ sv/bsa_divider.sv @@
// Restoring divider that produces one quotient bit per cycle.
`include "bitmap_slot_allocator_core_assert.svh"

module bsa_divider (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   input  logic [bsa_pkg::DIV_DIVIDEND_W-1:0]        dividend,
   input  logic [bsa_pkg::DIV_DIVISOR_W-1:0]         divisor,
   output bsa_pkg::bsa_div_result_type               result
);

   localparam logic [bsa_pkg::DIV_CNT_W-1:0] LAST_STEP =
      bsa_pkg::DIV_CNT_W'(bsa_pkg::DIV_DIVIDEND_W - 1);

   logic                                busy_ff;
   logic                                done_ff;
   logic [bsa_pkg::DIV_CNT_W-1:0]       cnt_ff;
   logic [bsa_pkg::DIV_DIVIDEND_W-1:0]  quo_ff;
   logic [bsa_pkg::DIV_DIVISOR_W-1:0]   rem_ff;
   logic [bsa_pkg::DIV_DIVISOR_W-1:0]   div_ff;
   logic [bsa_pkg::DIV_DIVISOR_W:0]     shifted;
   logic [bsa_pkg::DIV_DIVISOR_W:0]     trial;
   logic                                take;

   assign shifted = {rem_ff, quo_ff[bsa_pkg::DIV_DIVIDEND_W-1]};
   assign trial   = shifted - {1'b0, div_ff};
   assign take    = !trial[bsa_pkg::DIV_DIVISOR_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[bsa_pkg::DIV_DIVIDEND_W-2:0], take};
         rem_ff <= take ? trial[bsa_pkg::DIV_DIVISOR_W-1:0]
                        : shifted[bsa_pkg::DIV_DIVISOR_W-1:0];
      end
   end

   assign result.done      = done_ff;
   assign result.quotient  = quo_ff;
   assign result.remainder = rem_ff;

   `BSA_ASSERT_IMPL(a_no_restart, clock, reset, start, !busy_ff, "divider restarted while busy")
   `BSA_ASSERT_NEXT(a_done_pulse, clock, reset, done_ff, !done_ff, "divider done held")
   `BSA_ASSERT_IMPL(a_rem_bound, clock, reset, done_ff, rem_ff < div_ff, "remainder too large")

endmodule

@@ sv/bitmap_slot_allocator_core.sv @@
// Top level of the bitmap slot allocator: control sequencer, registers and result stage.
//
// Requests arrive on the req_ channel (req_mode 0 allocates, 1 frees req_free_address)
// and are taken when req_valid is high and req_stall is low. One request is worked on
// at a time. Every request gives exactly one transfer on the rsp_ channel carrying the
// status, the granted slot address and the count of used slots after the request.
// An allocate scans the bitmap memory one word per cycle. A free of an address at or above
// the object base with a nonzero slot size runs the offset through a bit-serial divider.
// The next request is taken as soon as the result sits in the output register; a stalled
// result holds there and the next finished result waits behind it.
// Configuration writes on the csr_ channel are always taken (csr_ready is high) and
// should be issued only while no request is outstanding.
// After reset the bitmap memory is cleared one word per cycle, during which req_stall
// stays high; the slot count is 1024, the slot size 64 and the base 0.
`include "bitmap_slot_allocator_core_assert.svh"

module bitmap_slot_allocator_core #(
   parameter int MAX_SLOTS     = 1024,
   parameter int MAP_WORD_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_mode,
   input  logic [bsa_pkg::ADDR_W-1:0]           req_free_address,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [bsa_pkg::STATUS_W-1:0]         rsp_status,
   output logic [bsa_pkg::ADDR_W-1:0]           rsp_slot_address,
   output logic [bsa_pkg::COUNT_REG_W-1:0]      rsp_slots_in_use,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bsa_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [bsa_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int MAP_WORDS = (MAX_SLOTS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BIT_W     = $clog2(MAP_WORD_BITS);
   localparam int IDX_W     = $clog2(MAX_SLOTS);
   localparam int CNT_RAW_W = $clog2(MAX_SLOTS + MAP_WORD_BITS + 1);
   localparam int CNT_W     = (CNT_RAW_W > bsa_pkg::COUNT_REG_W) ? CNT_RAW_W
                                                                 : bsa_pkg::COUNT_REG_W;
   localparam int PROD_W    = IDX_W + bsa_pkg::SIZE_W;
   localparam int RSH       = IDX_W;
   localparam int RCP_W     = RSH + 1;
   localparam int RCP       = (1 << RSH) / MAP_WORD_BITS;
   localparam int RPROD_W   = IDX_W + RCP_W;

   localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(MAP_WORDS - 1);
   localparam logic [CNT_W-1:0]   MAX_CNT   = CNT_W'(MAX_SLOTS);
   localparam logic [CNT_W-1:0]   WORD_CNT  = CNT_W'(MAP_WORD_BITS);
   localparam logic [RCP_W-1:0]   RCP_VAL   = RCP_W'(RCP);

   bsa_pkg::bsa_state_type state_ff, state_in;

   logic [bsa_pkg::COUNT_REG_W-1:0] slot_count_ff;
   logic [bsa_pkg::SIZE_W-1:0]      slot_size_ff;
   logic [bsa_pkg::ADDR_W-1:0]      object_base_ff;

   logic [CNT_W-1:0]   used_ff, used_in;
   logic [WADDR_W-1:0] word_ff, word_in;
   logic [CNT_W-1:0]   wbase_ff, wbase_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [WADDR_W-1:0] west_ff, west_in;
   logic [BIT_W-1:0]   fbit_ff, fbit_in;

   bsa_pkg::bsa_status_type    res_status_ff, res_status_in;
   logic [bsa_pkg::ADDR_W-1:0] res_addr_ff, res_addr_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   bsa_pkg::bsa_status_type         rsp_status_ff, rsp_status_in;
   logic [bsa_pkg::ADDR_W-1:0]      rsp_addr_ff, rsp_addr_in;
   logic [bsa_pkg::COUNT_REG_W-1:0] rsp_used_ff, rsp_used_in;

   logic                     rd_en;
   logic [WADDR_W-1:0]       rd_addr;
   logic [MAP_WORD_BITS-1:0] rd_data;
   logic                     wr_en;
   logic [WADDR_W-1:0]       wr_addr;
   logic [MAP_WORD_BITS-1:0] wr_data;

   logic                               div_start;
   bsa_pkg::bsa_div_result_type        div_res;

   logic [CNT_W-1:0]           live_n;
   logic [CNT_W-1:0]           remain;
   logic [CNT_W-1:0]           next_base;
   logic [MAP_WORD_BITS-1:0]   free_vec;
   logic                       hit;
   logic [BIT_W-1:0]           hit_bit;
   logic [bsa_pkg::ADDR_W-1:0] off;
   logic                       below;
   logic [RPROD_W-1:0]         rprod;
   logic [CNT_W-1:0]           frem;
   logic                       frem_over;
   logic                       req_take;
   logic                       out_free;
   logic                       div_bad;

   bsa_map_ram #(
      .WORDS (MAP_WORDS),
      .WIDTH (MAP_WORD_BITS),
      .AW    (WADDR_W)
   ) u_map (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   bsa_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (off),
      .divisor  (slot_size_ff),
      .result   (div_res)
   );

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != bsa_pkg::S_IDLE);
   assign req_take  = req_valid && (state_ff == bsa_pkg::S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign live_n    = (CNT_W'(slot_count_ff) > MAX_CNT) ? MAX_CNT : CNT_W'(slot_count_ff);
   assign remain    = live_n - wbase_ff;
   assign next_base = wbase_ff + WORD_CNT;
   assign off       = req_free_address - object_base_ff;
   assign below     = req_free_address < object_base_ff;
   assign rprod     = RPROD_W'(idx_ff) * RPROD_W'(RCP_VAL);
   assign frem      = CNT_W'(idx_ff) - CNT_W'(west_ff * MAP_WORD_BITS);
   assign frem_over = frem >= WORD_CNT;
   assign div_bad   = (div_res.remainder != '0) ||
                      (div_res.quotient >= bsa_pkg::DIV_DIVIDEND_W'(live_n));

   always_comb begin
      for (int b = 0; b < MAP_WORD_BITS; b++) begin
         free_vec[b] = !rd_data[b] && (CNT_W'(b) < remain);
      end
   end

   always_comb begin
      hit_bit = '0;
      for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
         if (free_vec[b]) begin
            hit_bit = BIT_W'(b);
         end
      end
   end

   assign hit = |free_vec;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bsa_pkg::S_CLEAR: begin
            if (word_ff == LAST_WORD) begin
               state_in = bsa_pkg::S_IDLE;
            end
         end
         bsa_pkg::S_IDLE: begin
            if (req_take) begin
               if (req_mode == bsa_pkg::MODE_ALLOC) begin
                  state_in = bsa_pkg::S_SCAN;
               end else if (below) begin
                  state_in = bsa_pkg::S_RESP;
               end else if (slot_size_ff == '0) begin
                  if (off != '0 || live_n == '0) begin
                     state_in = bsa_pkg::S_RESP;
                  end else begin
                     state_in = bsa_pkg::S_FREE_MUL;
                  end
               end else begin
                  state_in = bsa_pkg::S_DIVIDE;
               end
            end
         end
         bsa_pkg::S_SCAN: begin
            if (hit) begin
               state_in = bsa_pkg::S_ALLOC_MUL;
            end else if (next_base >= live_n) begin
               state_in = bsa_pkg::S_RESP;
            end
         end
         bsa_pkg::S_ALLOC_MUL: state_in = bsa_pkg::S_ALLOC_ADD;
         bsa_pkg::S_ALLOC_ADD: state_in = bsa_pkg::S_RESP;
         bsa_pkg::S_DIVIDE: begin
            if (div_res.done) begin
               state_in = div_bad ? bsa_pkg::S_RESP : bsa_pkg::S_FREE_MUL;
            end
         end
         bsa_pkg::S_FREE_MUL:   state_in = bsa_pkg::S_FREE_FIX;
         bsa_pkg::S_FREE_FIX:   state_in = bsa_pkg::S_FREE_CHECK;
         bsa_pkg::S_FREE_CHECK: state_in = bsa_pkg::S_RESP;
         bsa_pkg::S_RESP: begin
            if (out_free) begin
               state_in = bsa_pkg::S_IDLE;
            end
         end
         default: state_in = bsa_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      used_in       = used_ff;
      word_in       = word_ff;
      wbase_in      = wbase_ff;
      idx_in        = idx_ff;
      prod_in       = prod_ff;
      west_in       = west_ff;
      fbit_in       = fbit_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_used_in   = rsp_used_ff;
      rd_en         = 1'b0;
      rd_addr       = word_ff;
      wr_en         = 1'b0;
      wr_addr       = word_ff;
      wr_data       = rd_data;
      div_start     = 1'b0;
      case (state_ff)
         bsa_pkg::S_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = '0;
            word_in = word_ff + 1'b1;
         end
         bsa_pkg::S_IDLE: begin
            if (req_take) begin
               res_status_in = bsa_pkg::STATUS_OK;
               res_addr_in   = '0;
               if (req_mode == bsa_pkg::MODE_ALLOC) begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  word_in  = '0;
                  wbase_in = '0;
               end else if (below) begin
                  res_status_in = bsa_pkg::STATUS_RANGE;
               end else if (slot_size_ff == '0) begin
                  if (off != '0) begin
                     res_status_in = bsa_pkg::STATUS_MISALIGNED;
                  end else if (live_n == '0) begin
                     res_status_in = bsa_pkg::STATUS_RANGE;
                  end else begin
                     idx_in = '0;
                  end
               end else begin
                  div_start = 1'b1;
               end
            end
         end
         bsa_pkg::S_SCAN: begin
            if (hit) begin
               wr_en   = 1'b1;
               wr_data = rd_data | (MAP_WORD_BITS'(1) << hit_bit);
               used_in = used_ff + 1'b1;
               idx_in  = IDX_W'(wbase_ff + CNT_W'(hit_bit));
            end else if (next_base >= live_n) begin
               res_status_in = bsa_pkg::STATUS_FULL;
            end else begin
               word_in  = word_ff + 1'b1;
               wbase_in = next_base;
               rd_en    = 1'b1;
               rd_addr  = word_ff + 1'b1;
            end
         end
         bsa_pkg::S_ALLOC_MUL: begin
            prod_in = PROD_W'(idx_ff) * PROD_W'(slot_size_ff);
         end
         bsa_pkg::S_ALLOC_ADD: begin
            res_addr_in = object_base_ff + bsa_pkg::ADDR_W'(prod_ff);
         end
         bsa_pkg::S_DIVIDE: begin
            if (div_res.done) begin
               if (div_res.remainder != '0) begin
                  res_status_in = bsa_pkg::STATUS_MISALIGNED;
               end else if (div_bad) begin
                  res_status_in = bsa_pkg::STATUS_RANGE;
               end else begin
                  idx_in = IDX_W'(div_res.quotient);
               end
            end
         end
         bsa_pkg::S_FREE_MUL: begin
            west_in = WADDR_W'(rprod >> RSH);
         end
         bsa_pkg::S_FREE_FIX: begin
            rd_en = 1'b1;
            if (frem_over) begin
               word_in = west_ff + 1'b1;
               fbit_in = BIT_W'(frem - WORD_CNT);
            end else begin
               word_in = west_ff;
               fbit_in = BIT_W'(frem);
            end
            rd_addr = word_in;
         end
         bsa_pkg::S_FREE_CHECK: begin
            if (!rd_data[fbit_ff]) begin
               res_status_in = bsa_pkg::STATUS_NOT_ALLOCATED;
            end else begin
               wr_en   = 1'b1;
               wr_data = rd_data & ~(MAP_WORD_BITS'(1) << fbit_ff);
               used_in = used_ff - 1'b1;
            end
         end
         bsa_pkg::S_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = res_addr_ff;
               rsp_used_in   = used_ff[bsa_pkg::COUNT_REG_W-1:0];
            end
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsa_pkg::S_CLEAR;
         word_ff      <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wbase_ff      <= wbase_in;
      idx_ff        <= idx_in;
      prod_ff       <= prod_in;
      west_ff       <= west_in;
      fbit_ff       <= fbit_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_used_ff   <= rsp_used_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff  <= bsa_pkg::SLOT_COUNT_RESET;
         slot_size_ff   <= bsa_pkg::SLOT_SIZE_RESET;
         object_base_ff <= bsa_pkg::OBJECT_BASE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            bsa_pkg::CSR_SLOT_COUNT:  slot_count_ff  <= csr_wdata[bsa_pkg::COUNT_REG_W-1:0];
            bsa_pkg::CSR_SLOT_SIZE:   slot_size_ff   <= csr_wdata[bsa_pkg::SIZE_W-1:0];
            bsa_pkg::CSR_OBJECT_BASE: object_base_ff <= csr_wdata[bsa_pkg::ADDR_W-1:0];
            default: begin
               slot_count_ff <= slot_count_ff;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot_address = rsp_addr_ff;
   assign rsp_slots_in_use = rsp_used_ff;

   `BSA_ASSERT_IMPL(a_used_bound, clock, reset, 1'b1, used_ff <= MAX_CNT, "used count overflow")
   `BSA_ASSERT_IMPL(a_alloc_sets_one, clock, reset, wr_en && state_ff == bsa_pkg::S_SCAN, $countones(wr_data) == $countones(rd_data) + 1, "allocate did not set one bit")
   `BSA_ASSERT_IMPL(a_free_clears_one, clock, reset, wr_en && state_ff == bsa_pkg::S_FREE_CHECK, $countones(wr_data) + 1 == $countones(rd_data), "free did not clear one bit")
   `BSA_ASSERT_IMPL(a_fail_no_addr, clock, reset, rsp_valid_ff && rsp_status_ff != bsa_pkg::STATUS_OK, rsp_addr_ff == '0, "failed request carries an address")
   `BSA_ASSERT_NEXT(a_clear_ends, clock, reset, state_ff == bsa_pkg::S_CLEAR && word_ff == LAST_WORD, state_ff == bsa_pkg::S_IDLE, "clearing pass did not end")

endmodule

@@ tb/bitmap_slot_allocator_core_checker.sv @@
// Checker of the slot allocator: predicts each answer from the request transfers and compares.
module bitmap_slot_allocator_core_checker
   import bsa_pkg::*;
#(
   parameter int MAX_SLOTS = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic                   req_mode,
   input  logic [ADDR_W-1:0]      req_free_address,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [STATUS_W-1:0]    rsp_status,
   input  logic [ADDR_W-1:0]      rsp_slot_address,
   input  logic [COUNT_REG_W-1:0] rsp_slots_in_use,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     error_count,
   output int                     awaiting
);

   localparam int SLOT_IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

   typedef struct {
      bsa_status_type           status;
      logic [ADDR_W-1:0]        slot_address;
      logic [COUNT_REG_W-1:0]   slots_in_use;
   } slab_answer_type;

   bit                     slot_used [MAX_SLOTS];
   logic [COUNT_REG_W-1:0] used_slots  = '0;
   logic [COUNT_REG_W-1:0] slot_count  = SLOT_COUNT_RESET;
   logic [SIZE_W-1:0]      slot_size   = SLOT_SIZE_RESET;
   logic [ADDR_W-1:0]      object_base = OBJECT_BASE_RESET;
   slab_answer_type        pending_answers [$];
   int                     failures = 0;
   int                     waiting_count = 0;

   assign error_count = failures;
   assign awaiting    = waiting_count;

   function automatic slab_answer_type serve_request(input logic mode,
                                                     input logic [ADDR_W-1:0] address);
      slab_answer_type   answer;
      logic [31:0]       live;
      logic [31:0]       slot;
      logic [ADDR_W-1:0] offset;
      bit                found;
      int                i;
      answer.status       = STATUS_OK;
      answer.slot_address = '0;
      live  = (slot_count > MAX_SLOTS) ? MAX_SLOTS : slot_count;
      slot  = 0;
      found = 1'b0;
      if (mode == MODE_ALLOC) begin
         for (i = 0; i < live && !found; i++) begin
            if (!slot_used[SLOT_IDX_W'(i)]) begin
               found = 1'b1;
               slot  = i;
            end
         end
         if (!found) begin
            answer.status = STATUS_FULL;
         end else begin
            slot_used[SLOT_IDX_W'(slot)] = 1'b1;
            used_slots          = used_slots + 1'b1;
            answer.slot_address = object_base + slot * slot_size;
         end
      end else if (address < object_base) begin
         answer.status = STATUS_RANGE;
      end else begin
         offset = address - object_base;
         if (slot_size == 0) begin
            if (offset != 0) begin
               answer.status = STATUS_MISALIGNED;
            end
         end else if (offset % slot_size != 0) begin
            answer.status = STATUS_MISALIGNED;
         end else begin
            slot = offset / slot_size;
         end
         if (answer.status == STATUS_OK) begin
            if (slot >= live) begin
               answer.status = STATUS_RANGE;
            end else if (!slot_used[SLOT_IDX_W'(slot)]) begin
               answer.status = STATUS_NOT_ALLOCATED;
            end else begin
               slot_used[SLOT_IDX_W'(slot)] = 1'b0;
               used_slots      = used_slots - 1'b1;
            end
         end
      end
      answer.slots_in_use = used_slots;
      return answer;
   endfunction

   always @(posedge clock) begin
      slab_answer_type want;
      if (reset) begin
         foreach (slot_used[i]) slot_used[i] = 1'b0;
         used_slots  = '0;
         slot_count  = SLOT_COUNT_RESET;
         slot_size   = SLOT_SIZE_RESET;
         object_base = OBJECT_BASE_RESET;
         pending_answers.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SLOT_COUNT: begin
                  slot_count = csr_wdata[COUNT_REG_W-1:0];
               end
               CSR_SLOT_SIZE: begin
                  slot_size = csr_wdata[SIZE_W-1:0];
               end
               CSR_OBJECT_BASE: begin
                  object_base = csr_wdata[ADDR_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_answers.size() == 0) begin
               $error("result transfer with no request waiting: status %0d, address %0h",
                      rsp_status, rsp_slot_address);
               failures++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  failures++;
               end
               if (rsp_slot_address !== want.slot_address) begin
                  $error("slot_address: expected %0h, actual %0h",
                         want.slot_address, rsp_slot_address);
                  failures++;
               end
               if (rsp_slots_in_use !== want.slots_in_use) begin
                  $error("slots_in_use: expected %0d, actual %0d",
                         want.slots_in_use, rsp_slots_in_use);
                  failures++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            pending_answers.push_back(serve_request(req_mode, req_free_address));
         end
      end
      waiting_count = pending_answers.size();
   end

endmodule

@@ tb/bitmap_slot_allocator_core_test.sv @@
// Top of the slot allocator testbench: clock, reset, stimulus, back pressure and verdict.
module bitmap_slot_allocator_core_test;
   import bsa_pkg::*;

   localparam int MAX_SLOTS    = 1024;
   localparam int RANDOM_ITEMS = 1600;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE_TAIL  = 60;
   localparam int CYCLE_LIMIT  = 1500000;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_mode = MODE_ALLOC;
   logic [ADDR_W-1:0]      req_free_address = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [STATUS_W-1:0]    rsp_status;
   logic [ADDR_W-1:0]      rsp_slot_address;
   logic [COUNT_REG_W-1:0] rsp_slots_in_use;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_SLOT_COUNT;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int                     error_count;
   int                     awaiting;
   int                     cycle_count = 0;
   int                     items_sent = 0;
   bit                     calm = 1'b0;
   bit                     hold_request = 1'b0;

   logic [COUNT_REG_W-1:0] cfg_count = SLOT_COUNT_RESET;
   logic [SIZE_W-1:0]      cfg_size  = SLOT_SIZE_RESET;
   logic [ADDR_W-1:0]      cfg_base  = OBJECT_BASE_RESET;

   bitmap_slot_allocator_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_free_address (req_free_address),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_slot_address (rsp_slot_address),
      .rsp_slots_in_use (rsp_slots_in_use),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   bitmap_slot_allocator_core_checker #(
      .MAX_SLOTS (MAX_SLOTS)
   ) slab_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_free_address (req_free_address),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_slot_address (rsp_slot_address),
      .rsp_slots_in_use (rsp_slots_in_use),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .error_count      (error_count),
      .awaiting         (awaiting)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 60) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [ADDR_W-1:0] pick_free_address();
      int unsigned       roll;
      int unsigned       live;
      int unsigned       k;
      logic [ADDR_W-1:0] aligned;
      live    = (cfg_count > MAX_SLOTS) ? MAX_SLOTS : cfg_count;
      k       = $urandom_range(0, live + 1);
      aligned = cfg_base + k * cfg_size;
      roll    = $urandom_range(0, 99);
      if (roll < 72) begin
         return aligned;
      end else if (roll < 82) begin
         return aligned + $urandom_range(1, (cfg_size > 1) ? cfg_size - 1 : 1);
      end else if (roll < 90) begin
         return cfg_base - $urandom_range(1, 4096);
      end
      return $urandom();
   endfunction

   task automatic push_request(input logic mode, input logic [ADDR_W-1:0] address);
      int unsigned gap;
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_free_address <= (mode == MODE_FREE) ? address : $urandom();
      do @(posedge clock); while (!(req_valid && !req_stall));
      items_sent++;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic settle();
      if (req_valid) begin
         req_valid <= 1'b0;
      end
      do @(posedge clock); while (awaiting != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input logic [COUNT_REG_W-1:0] count,
                            input logic [SIZE_W-1:0] size,
                            input logic [ADDR_W-1:0] base,
                            input logic [2:0] which,
                            input bit spare);
      logic [CSR_DATA_W-1:0] data;
      settle();
      if (which[0]) begin
         data = $urandom();
         data[COUNT_REG_W-1:0] = count;
         write_register(CSR_SLOT_COUNT, data);
         cfg_count = count;
      end
      if (which[1]) begin
         data = $urandom();
         data[SIZE_W-1:0] = size;
         write_register(CSR_SLOT_SIZE, data);
         cfg_size = size;
      end
      if (which[2]) begin
         write_register(CSR_OBJECT_BASE, base);
         cfg_base = base;
      end
      if (spare) begin
         write_register(CSR_SPARE, $urandom());
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      int unsigned roll;
      int unsigned span;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
            rsp_stall <= 1'b0;
         end else if (calm) begin
            rsp_stall <= 1'b0;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
               span = $urandom_range(1, 20);
            end else if (roll < 92) begin
               span = $urandom_range(1, 3);
            end else begin
               span = $urandom_range(10, 60);
            end
            rsp_stall <= (roll >= 55);
            repeat (span - 1) @(posedge clock);
         end
      end
   end

   initial begin
      int unsigned            phase;
      int unsigned            length;
      int unsigned            alloc_pct;
      int unsigned            roll;
      logic [COUNT_REG_W-1:0] count;
      logic [SIZE_W-1:0]      size;
      logic [ADDR_W-1:0]      base;
      logic                   mode;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      push_request(MODE_FREE, 32'h0000_0000);
      push_request(MODE_ALLOC, 32'hFFFF_FFFF);
      push_request(MODE_ALLOC, 32'h0000_0000);
      push_request(MODE_FREE, 32'h0000_0040);
      push_request(MODE_FREE, 32'h0000_0040);
      push_request(MODE_FREE, 32'h0000_0041);
      push_request(MODE_FREE, 32'h0001_0000);
      push_request(MODE_FREE, 32'hFFFF_FFFF);
      push_request(MODE_FREE, 32'hFFFF_FFC0);

      configure(11'd0, cfg_size, cfg_base, 3'b001, 1'b0);
      push_request(MODE_ALLOC, 32'h0);
      push_request(MODE_FREE, 32'h0000_0000);

      configure(11'd3, 16'd0, 32'h8000_0000, 3'b111, 1'b0);
      push_request(MODE_ALLOC, 32'h0);
      push_request(MODE_FREE, 32'h8000_0000);
      push_request(MODE_FREE, 32'h8000_0001);
      push_request(MODE_FREE, 32'h7FFF_FFFF);
      push_request(MODE_FREE, 32'h8000_0000);
      push_request(MODE_ALLOC, 32'h0);
      push_request(MODE_ALLOC, 32'h0);
      push_request(MODE_ALLOC, 32'h0);

      configure(11'd2047, 16'hFFFF, 32'hFFFF_0000, 3'b111, 1'b1);
      push_request(MODE_ALLOC, 32'h0);
      push_request(MODE_FREE, 32'h0002_FFFD);
      push_request(MODE_FREE, 32'hFFFF_0000);
      push_request(MODE_ALLOC, 32'h0);
      push_request(MODE_FREE, 32'hFFFF_FFFF);

      phase = 0;
      while (items_sent < RANDOM_ITEMS + 25) begin
         roll = $urandom_range(0, 99);
         if (roll < 15) begin
            case ($urandom_range(0, 3))
               0: count = 11'd0;
               1: count = 11'd1;
               2: count = 11'd1024;
               default: count = 11'd2047;
            endcase
         end else if (roll < 75) begin
            count = COUNT_REG_W'($urandom_range(1, 40));
         end else begin
            count = COUNT_REG_W'($urandom_range(1, 2047));
         end
         roll = $urandom_range(0, 99);
         if (roll < 10) begin
            size = 16'd0;
         end else if (roll < 20) begin
            size = 16'd1;
         end else if (roll < 30) begin
            size = 16'hFFFF;
         end else if (roll < 75) begin
            size = SIZE_W'($urandom_range(1, 300));
         end else begin
            size = SIZE_W'($urandom());
         end
         roll = $urandom_range(0, 99);
         if (roll < 20) begin
            base = 32'h0;
         end else if (roll < 30) begin
            base = 32'hFFFF_FFFF;
         end else if (roll < 40) begin
            base = 32'hFFFF_FFFF - $urandom_range(0, 1 << 20);
         end else begin
            base = $urandom();
         end
         alloc_pct = $urandom_range(25, 85);
         length    = $urandom_range(20, 100);
         if (phase == 2) begin
            count     = 11'd1024;
            size      = SIZE_W'($urandom_range(1, 8));
            alloc_pct = 95;
            length    = 160;
            configure(count, size, base, 3'b111, 1'b0);
         end else begin
            configure(count, size, base, 3'($urandom_range(1, 7)), $urandom_range(0, 9) == 0);
         end
         calm = ($urandom_range(0, 3) == 0);
         if (phase == 0 || $urandom_range(0, 7) == 0) begin
            hold_request = 1'b1;
         end
         repeat (length) begin
            mode = ($urandom_range(0, 99) < alloc_pct) ? MODE_ALLOC : MODE_FREE;
            push_request(mode, pick_free_address());
         end
         phase++;
      end

      settle();
      repeat (SETTLE_TAIL) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+sv
sv/bsa_pkg.sv
sv/bsa_map_ram.sv
sv/bsa_divider.sv
sv/bitmap_slot_allocator_core.sv
tb/bitmap_slot_allocator_core_checker.sv
tb/bitmap_slot_allocator_core_test.sv
